### src/tss_pkg.sv
// throttle safety supervisor package: field widths, phase codes, register
// indexes and the item, result and configuration structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package tss_pkg;

    localparam int unsigned POS_W   = 16;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned COUNT_W = 17;
    localparam int unsigned PHASE_W = 2;
    localparam int unsigned CFG_IDX_W = 2;

    // input beat: 35 bits of fields, padded to 40
    localparam int unsigned S_TDATA_W = 40;
    // result beat: 6 bits of fields, padded to 8
    localparam int unsigned M_TDATA_W = 8;

    // supervisor phase codes
    localparam logic [PHASE_W-1:0] PH_POLL = 2'd0;
    localparam logic [PHASE_W-1:0] PH_OFF  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_REC  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DEVIATION   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_OFF_TICKS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVER_TICKS   = 2'd3;

    // register reset values
    localparam logic [CFG_W-1:0] RST_MAX_DEVIATION   = 16'd410;
    localparam logic [CFG_W-1:0] RST_TRIGGER_TICKS   = 16'd500;
    localparam logic [CFG_W-1:0] RST_POWER_OFF_TICKS = 16'd1000;
    localparam logic [CFG_W-1:0] RST_RECOVER_TICKS   = 16'd1000;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [CFG_W-1:0] max_deviation;
        logic [CFG_W-1:0] trigger_ticks;
        logic [CFG_W-1:0] power_off_ticks;
        logic [CFG_W-1:0] recover_ticks;
    } tss_cfg_t;

    typedef struct packed {
        logic             throttle_at_idle;
        logic             throttle_sensor_fault;
        logic             pedal_sensor_fault;
        logic [POS_W-1:0] target_position;
        logic [POS_W-1:0] throttle_position;
    } tss_item_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               safety_line_on;
        logic               clear_faults;
        logic               disable_request;
        logic               recover_pulse;
    } tss_result_t;

endpackage
`default_nettype wire

### src/tss_cfg_regs.sv
// configuration register file of the throttle safety supervisor
// depends on tss_pkg
`timescale 1ns / 1ps
`default_nettype none
module tss_cfg_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [tss_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [tss_pkg::CFG_W-1:0]     cfg_wr_data,
    output tss_pkg::tss_cfg_t                  cfg
);
    import tss_pkg::*;

    tss_cfg_t cfg_reg;

    // register writes, indexed by address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_deviation   <= RST_MAX_DEVIATION;
            cfg_reg.trigger_ticks   <= RST_TRIGGER_TICKS;
            cfg_reg.power_off_ticks <= RST_POWER_OFF_TICKS;
            cfg_reg.recover_ticks   <= RST_RECOVER_TICKS;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_MAX_DEVIATION:   cfg_reg.max_deviation   <= cfg_wr_data;
                REG_TRIGGER_TICKS:   cfg_reg.trigger_ticks   <= cfg_wr_data;
                REG_POWER_OFF_TICKS: cfg_reg.power_off_ticks <= cfg_wr_data;
                REG_RECOVER_TICKS:   cfg_reg.recover_ticks   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

### src/tss_step.sv
// supervisor state machine: phase, tick counter and line level, plus the
// combinational step that turns one tick into one result
// depends on tss_pkg
`timescale 1ns / 1ps
`default_nettype none
module tss_step (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          advance,
    input  wire tss_pkg::tss_item_t item,
    input  wire tss_pkg::tss_cfg_t  cfg,
    output tss_pkg::tss_result_t result
);
    import tss_pkg::*;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               line_reg, line_next;

    logic [POS_W-1:0]   diff;
    logic               healthy;
    logic               any_fault;
    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] count_poll;
    logic [COUNT_W-1:0] count_rec;
    logic [COUNT_W-1:0] trig_ext, off_ext, rec_ext;
    logic               recover_pulse, disable_request;

    // deviation check
    assign diff = (item.throttle_position >= item.target_position)
                ? item.throttle_position - item.target_position
                : item.target_position - item.throttle_position;
    assign healthy   = (diff <= cfg.max_deviation);
    assign any_fault = item.pedal_sensor_fault | item.throttle_sensor_fault;

    // saturating increment and widened limits
    assign count_inc = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 1'b1;
    assign trig_ext  = {1'b0, cfg.trigger_ticks};
    assign off_ext   = {1'b0, cfg.power_off_ticks};
    assign rec_ext   = {1'b0, cfg.recover_ticks};

    assign count_poll = healthy ? '0
                      : ((count_reg <= trig_ext) ? count_inc : count_reg);
    assign count_rec  = (healthy && item.throttle_at_idle) ? count_inc : '0;

    // phase transitions
    always_comb begin
        phase_next      = phase_reg;
        count_next      = count_reg;
        line_next       = line_reg;
        recover_pulse   = 1'b0;
        disable_request = 1'b0;
        unique case (phase_reg)
            PH_POLL: begin
                count_next = count_poll;
                if (count_poll > trig_ext || any_fault) begin
                    disable_request = 1'b1;
                    count_next      = '0;
                    phase_next      = PH_OFF;
                end
            end
            PH_OFF: begin
                if (item.throttle_at_idle) begin
                    count_next = '0;
                    phase_next = PH_REC;
                end else if (count_inc > off_ext) begin
                    line_next  = 1'b0;
                    count_next = '0;
                    phase_next = PH_REC;
                end else begin
                    count_next = count_inc;
                end
            end
            // recovery, and the unused code handled the same way
            default: begin
                if (count_rec > rec_ext) begin
                    line_next     = 1'b1;
                    recover_pulse = 1'b1;
                    count_next    = '0;
                    phase_next    = PH_POLL;
                end else begin
                    count_next = count_rec;
                    phase_next = PH_REC;
                end
            end
        endcase
    end

    // state update once per tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_POLL;
            count_reg <= '0;
            line_reg  <= 1'b1;
        end else if (advance) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            line_reg  <= line_next;
        end
    end

    assign result.recover_pulse   = recover_pulse;
    assign result.disable_request = disable_request;
    assign result.clear_faults    = disable_request;
    assign result.safety_line_on  = line_next;
    assign result.phase           = phase_next;

endmodule
`default_nettype wire

### src/throttle_safety_supervisor_unit.sv
// Throttle safety supervisor, top level: input register, step logic, result register.
// Throughput: one tick per clock unless m_tready stalls the result stage; the next
// beat is taken while a result still waits.
// Reset (aresetn low, synchronous): phase polling, tick count zero, safety line on,
// registers at defaults, both stages empty.
// depends on tss_pkg, tss_cfg_regs, tss_step
`timescale 1ns / 1ps
`default_nettype none
module throttle_safety_supervisor_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // throttle_position[15:0], target_position[31:16], pedal_sensor_fault[32],
    // throttle_sensor_fault[33], throttle_at_idle[34], zero[39:35]
    input  wire logic [tss_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          s_tvalid,
    output wire logic                          s_tready,
    // recover_pulse[0], disable_request[1], clear_faults[2], safety_line_on[3],
    // phase[5:4], zero[7:6]
    output wire logic [tss_pkg::M_TDATA_W-1:0] m_tdata,
    output wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic                          cfg_wr_en,
    input  wire logic [tss_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [tss_pkg::CFG_W-1:0]     cfg_wr_data
);
    import tss_pkg::*;

    localparam int unsigned ITEM_W = $bits(tss_item_t);
    localparam int unsigned RES_W  = $bits(tss_result_t);

    tss_cfg_t    cfg;
    tss_item_t   in_item_reg;
    logic        in_valid_reg;
    tss_result_t result;
    tss_result_t out_reg;
    logic        out_valid_reg;
    logic        advance;
    logic        in_take;

    // stage handoff
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    tss_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_item_reg <= s_tdata[ITEM_W-1:0];
        end
    end

    tss_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-RES_W){1'b0}}, out_reg};

endmodule
`default_nettype wire
